FILE: rtl/core/uart_frame_receiver_unit_defines.svh
// Assertion macros for the UART frame receiver.
// Used by the top level only; no other dependencies.
`ifndef UART_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define UART_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define UFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uart frame receiver check failed");

// Next-cycle implication, checked out of reset.
`define UFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uart frame receiver check failed");

`endif

FILE: rtl/core/ufr_pkg.sv
// Shared constants and result type for the UART frame receiver.
// No dependencies.
package ufr_pkg;

    localparam logic [7:0] HEADER_BYTE  = 8'h55;
    localparam logic [7:0] CMD_LIMIT    = 8'h03;
    localparam logic [7:0] TRAILER_BYTE = 8'hAA;
    localparam int         IDX_W        = 7;

    typedef struct packed {
        logic [7:0]       stored_byte;
        logic [IDX_W-1:0] byte_index;
        logic             frame_valid;
    } t_result;

endpackage

FILE: rtl/core/ufr_tracker.sv
// Frame tracker: position, length and checksum state, and the result of each byte.
// Depends on ufr_pkg.
module ufr_tracker #(
    parameter int MAX_LEN = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_rx_byte,
    output ufr_pkg::t_result o_result
);
    import ufr_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 5);
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam logic [7:0]       MAX_LEN_B = 8'(MAX_LEN);
    localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_TWO   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_THREE = POS_W'(3);
    localparam logic [POS_W-1:0] POS_FOUR  = POS_W'(4);

    logic [POS_W-1:0]       r_pos, n_pos;
    logic [LEN_W-1:0]       r_len, n_len;
    logic [7:0]             r_sum, n_sum;
    logic [POS_W-1:0]       pos_inc;
    logic [POS_W-1:0]       len_ext;
    logic [7:0]             sum_add;
    logic [LEN_W+7:0]       byte_wide;
    logic [POS_W+LEN_W-1:0] len_wide;
    logic [POS_W+IDX_W-1:0] idx_wide;
    logic                   frame_valid;

    assign byte_wide = {{LEN_W{1'b0}}, i_rx_byte};
    assign len_wide  = {{POS_W{1'b0}}, r_len};
    assign len_ext   = len_wide[POS_W-1:0];
    assign pos_inc   = r_pos + POS_ONE;
    assign sum_add   = r_sum + i_rx_byte;
    assign idx_wide  = {{IDX_W{1'b0}}, r_pos};

    always_comb begin
        n_pos       = r_pos;
        n_len       = r_len;
        n_sum       = r_sum;
        frame_valid = 1'b0;
        if (r_pos == '0) begin
            if (i_rx_byte == HEADER_BYTE) begin
                n_pos = POS_ONE;
            end
        end else if (r_pos == POS_ONE) begin
            if (i_rx_byte < CMD_LIMIT) begin
                n_pos = POS_TWO;
                n_sum = i_rx_byte;
            end else begin
                n_pos = '0;
            end
        end else if (r_pos == POS_TWO) begin
            // a length that fits is kept even when zero aborts the frame
            if (i_rx_byte <= MAX_LEN_B) begin
                n_len = byte_wide[LEN_W-1:0];
            end
            if (i_rx_byte != 8'h00 && i_rx_byte <= MAX_LEN_B) begin
                n_pos = POS_THREE;
                n_sum = sum_add;
            end else begin
                n_pos = '0;
            end
        end else begin
            n_pos = pos_inc;
            n_sum = sum_add;
            if (pos_inc >= len_ext + POS_FOUR) begin
                frame_valid = (i_rx_byte == TRAILER_BYTE);
                n_pos       = '0;
            end else if (pos_inc == len_ext + POS_THREE) begin
                // drop the frame on a bad checksum
                if (sum_add != 8'h00) begin
                    n_pos = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_len <= '0;
            r_sum <= '0;
        end else if (i_take) begin
            r_pos <= n_pos;
            r_len <= n_len;
            r_sum <= n_sum;
        end
    end

    assign o_result.stored_byte = i_rx_byte;
    assign o_result.byte_index  = idx_wide[IDX_W-1:0];
    assign o_result.frame_valid = frame_valid;

endmodule

FILE: rtl/core/ufr_out_buf.sv
// Two-entry output buffer (result register plus skid stage) for result beats.
// Depends on ufr_pkg.
module ufr_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ufr_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output ufr_pkg::t_result o_data
);
    import ufr_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out_data, n_out_data;
    t_result r_skid_data, n_skid_data;
    logic    push, pop;

    assign o_ready = !r_skid_valid;
    assign push    = i_valid && !r_skid_valid;
    assign pop     = r_out_valid && i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_data   = r_out_data;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            // drain the skid stage first
            if (pop) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                n_out_data  = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid_data  = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

FILE: rtl/core/uart_frame_receiver_unit.sv
// UART frame receiver top level: frame tracker feeding a two-entry result buffer.
// Depends on ufr_pkg, ufr_tracker, ufr_out_buf and the assertion macro header.
//
// Usage:
//   Input channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one received byte per beat.
//   Output channel (o_res_valid / i_res_ready) gives one result beat per input beat:
//   o_stored_byte, its frame offset o_byte_index, and o_frame_valid, set on a 0xAA
//   trailer that closes a frame with a good header, command, length and checksum.
//   Frames look like 0x55, command, length, length bytes ending in a checksum, 0xAA.
//   Buffering: a byte's result is registered in the output register or in the skid stage.
//   Throughput: one byte per cycle while o_rx_ready is high; the frame state updates
//   in the cycle the byte is taken, so the next byte may follow directly.
//   Stalls: a result waits in the output register while a second one fits in the
//   skid stage; o_rx_ready drops only when both are full and returns once the
//   receiver takes a beat.
//   Reset (i_rst_n low, synchronous): the tracker returns to header hunting with
//   length and checksum cleared, and both buffer entries are emptied.
`include "uart_frame_receiver_unit_defines.svh"
module uart_frame_receiver_unit #(
    parameter int MAX_LEN = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rx_valid,
    output logic                    o_rx_ready,
    input  logic [7:0]              i_rx_byte,
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output logic [7:0]              o_stored_byte,
    output logic [ufr_pkg::IDX_W-1:0] o_byte_index,
    output logic                    o_frame_valid
);
    import ufr_pkg::*;

    t_result trk_result;
    t_result res_data;
    logic    rx_take;

    assign rx_take = i_rx_valid && o_rx_ready;

    ufr_tracker #(
        .MAX_LEN(MAX_LEN)
    ) u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (rx_take),
        .i_rx_byte(i_rx_byte),
        .o_result (trk_result)
    );

    ufr_out_buf u_out_buf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_rx_valid),
        .o_ready(o_rx_ready),
        .i_data (trk_result),
        .o_valid(o_res_valid),
        .i_ready(i_res_ready),
        .o_data (res_data)
    );

    assign o_stored_byte = res_data.stored_byte;
    assign o_byte_index  = res_data.byte_index;
    assign o_frame_valid = res_data.frame_valid;

    `UFR_ASSERT_NOW(a_valid_is_trailer, i_clk, i_rst_n, o_res_valid && o_frame_valid, o_stored_byte == TRAILER_BYTE)
    `UFR_ASSERT_NOW(a_full_has_result, i_clk, i_rst_n, !o_rx_ready, o_res_valid)
    `UFR_ASSERT_NEXT(a_empty_fill, i_clk, i_rst_n, rx_take && !o_res_valid, o_res_valid && o_stored_byte == $past(i_rx_byte))

endmodule

FILE: sim/uart_frame_receiver_unit_tb.sv
// Self-checking testbench for uart_frame_receiver_unit: directed and random frames on the rx
// channel, results checked in order against a cycle-free frame tracker in a scoreboard class.
// Depends on ufr_pkg and the uart_frame_receiver_unit RTL.
module uart_frame_receiver_unit_tb;
    import ufr_pkg::*;

    localparam int MAX_LEN      = 64;
    localparam int RANDOM_BEATS = 1650;
    localparam int PRESS_AT     = 400;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_SLACK  = 8;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int SHOWN_ERRORS = 10;

    class frame_scoreboard;
        t_result    due_results[$];
        int         errors;
        int         offset;
        int         frame_len;
        logic [7:0] frame_sum;

        function new();
            errors    = 0;
            offset    = 0;
            frame_len = 0;
            frame_sum = 8'h00;
        endfunction

        // Advance the frame tracker by one byte and queue the result it causes.
        function void note_rx_byte(logic [7:0] b);
            t_result r;
            int      at;
            at            = offset;
            r.stored_byte = b;
            r.byte_index  = at[IDX_W-1:0];
            r.frame_valid = 1'b0;
            if (at == 0) begin
                if (b == HEADER_BYTE) offset = 1;
            end else if (at == 1) begin
                if (b < CMD_LIMIT) begin
                    offset    = 2;
                    frame_sum = b;
                end else begin
                    offset = 0;
                end
            end else if (at == 2) begin
                if (b != 8'h00 && int'(b) <= MAX_LEN) begin
                    offset    = 3;
                    frame_len = int'(b);
                    frame_sum = frame_sum + b;
                end else begin
                    if (int'(b) <= MAX_LEN) frame_len = int'(b);
                    offset = 0;
                end
            end else begin
                offset    = at + 1;
                frame_sum = frame_sum + b;
                if (offset >= frame_len + 4) begin
                    r.frame_valid = (b == TRAILER_BYTE);
                    offset        = 0;
                end else if (offset == frame_len + 3) begin
                    if (frame_sum != 8'h00) offset = 0;
                end
            end
            due_results.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("unexpected result: byte %02h index %0d valid %0b",
                             got.stored_byte, got.byte_index, got.frame_valid);
                return;
            end
            want = due_results.pop_front();
            if (got.stored_byte !== want.stored_byte || got.byte_index !== want.byte_index ||
                got.frame_valid !== want.frame_valid) begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("result mismatch: expected byte %02h index %0d valid %0b, got %02h %0d %0b",
                             want.stored_byte, want.byte_index, want.frame_valid,
                             got.stored_byte, got.byte_index, got.frame_valid);
            end
        endfunction
    endclass

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_rx_valid  = 1'b0;
    logic             o_rx_ready;
    logic [7:0]       i_rx_byte   = 8'h00;
    logic             o_res_valid;
    logic             i_res_ready = 1'b0;
    logic [7:0]       o_stored_byte;
    logic [IDX_W-1:0] o_byte_index;
    logic             o_frame_valid;

    frame_scoreboard sb = new();
    int              rx_beats      = 0;
    int              frame_beats   = 0;
    int              tx_quiet_left = 0;
    int              cycles        = 0;

    logic [7:0] directed_bytes [$] = '{
        8'h00, 8'hFF,                                   // ignored while hunting
        HEADER_BYTE, CMD_LIMIT,                         // command too large
        HEADER_BYTE, HEADER_BYTE,                       // header as command, not rescanned
        HEADER_BYTE, 8'h00, 8'h00,                      // zero length
        HEADER_BYTE, 8'h00, 8'h41,                      // length one above the limit
        HEADER_BYTE, 8'h00, 8'h01, 8'hFF, TRAILER_BYTE, // good frame
        HEADER_BYTE, 8'h02, 8'h01, 8'hFD, 8'h00,        // wrong trailer
        HEADER_BYTE, 8'h01, 8'h02, 8'h00, 8'h00         // bad checksum
    };

    uart_frame_receiver_unit #(
        .MAX_LEN(MAX_LEN)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_stored_byte(o_stored_byte),
        .o_byte_index (o_byte_index),
        .o_frame_valid(o_frame_valid)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit counts);
        int gap;
        gap = (tx_quiet_left > 0) ? 0 : pick_gap();
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        sb.note_rx_byte(b);
        rx_beats++;
        if (counts) frame_beats++;
    endtask

    task automatic send_frame();
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        int         kind;
        int         flaw;
        int         n;
        if (tx_quiet_left > 0) tx_quiet_left--;
        else if ($urandom_range(0, 9) == 0) tx_quiet_left = $urandom_range(2, 6);
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
            return;
        end
        flaw = (kind >= 80) ? $urandom_range(1, 4) : 0;
        send_byte(HEADER_BYTE, 1'b1);
        if (flaw == 1) begin
            send_byte(8'($urandom_range(int'(CMD_LIMIT), 255)), 1'b1);
            return;
        end
        cmd = 8'($urandom_range(0, int'(CMD_LIMIT) - 1));
        send_byte(cmd, 1'b1);
        if (flaw == 2) begin
            b = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(MAX_LEN + 1, 255));
            send_byte(b, 1'b1);
            return;
        end
        n = $urandom_range(0, 99);
        if (n < 5) len = 8'(MAX_LEN);
        else if (n < 15) len = 8'($urandom_range(1, MAX_LEN));
        else len = 8'($urandom_range(1, 8));
        send_byte(len, 1'b1);
        sum = cmd + len;
        for (int i = 1; i < int'(len); i++) begin
            b = 8'($urandom_range(0, 255));
            send_byte(b, 1'b1);
            sum = sum + b;
        end
        b = 8'h00 - sum;
        if (flaw == 3) b = b ^ 8'($urandom_range(1, 255));
        send_byte(b, 1'b1);
        if (flaw == 3) return;
        b = (flaw == 4) ? (TRAILER_BYTE ^ 8'($urandom_range(1, 255))) : TRAILER_BYTE;
        send_byte(b, 1'b1);
    endtask

    // Result side: check each accepted beat, stall at random, once hold off long.
    initial begin : res_sink
        int hold_left;
        int quiet_left;
        int r;
        bit pressed;
        hold_left  = 0;
        quiet_left = 0;
        pressed    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_res_valid && i_res_ready)
                sb.check_result('{stored_byte: o_stored_byte, byte_index: o_byte_index,
                                  frame_valid: o_frame_valid});
            if (!pressed && rx_beats >= PRESS_AT) begin
                pressed   = 1'b1;
                hold_left = LONG_HOLD;
            end else if (hold_left == 0 && quiet_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 3) quiet_left = $urandom_range(50, 200);
                else if (r < 30) hold_left = pick_gap();
            end
            if (hold_left > 0) begin
                i_res_ready <= 1'b0;
                hold_left--;
            end else begin
                i_res_ready <= 1'b1;
                if (quiet_left > 0) quiet_left--;
            end
        end
    end

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_bytes[i]) send_byte(directed_bytes[i], 1'b0);
        while (frame_beats < RANDOM_BEATS) send_frame();
        i_rx_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/ufr_pkg.sv
rtl/core/ufr_tracker.sv
rtl/core/ufr_out_buf.sv
rtl/core/uart_frame_receiver_unit.sv
sim/uart_frame_receiver_unit_tb.sv
